// File: rtl/core/ptts_pkg.sv
// ptts_pkg: shared constants, codes and types of the periodic task tick scheduler
// used by ptts_cell and periodic_task_tick_scheduler_core; no dependencies
`default_nettype none

package ptts_pkg;

  localparam int NUM_TASKS = 8;

  localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int MCNT_W = $clog2(NUM_TASKS + 1);
  localparam int CMP_W  = (IDX_W + 1 > 4) ? IDX_W + 1 : 4;
  localparam int MASK_N = (NUM_TASKS < 8) ? NUM_TASKS : 8;

  localparam int TIME_W     = 32;
  localparam int PER_W      = 16;
  localparam int TASK_W     = 3;
  localparam int MASK_W     = 8;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 1'd1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } st_t;

  // per-cell control strobes and active flag
  typedef struct packed {
    logic rel;
    logic ld;
    logic dec;
    logic act;
  } cell_ctl_t;

  // running best candidate and miss tally handed down the row
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] key;
    logic [IDX_W-1:0]  sel;
    logic [MCNT_W-1:0] misses;
  } chain_t;

endpackage

`default_nettype wire

// File: rtl/core/periodic_task_tick_scheduler_core.sv
// periodic_task_tick_scheduler_core: top level, sequencer, counters and row of cells
// depends on ptts_pkg and ptts_cell
//
//   channel | direction | handshake          | payload
//   in      | sink      | in_valid/in_stall  | opcode, task_index, arrival, period, burst
//   out     | source    | out_valid/out_stall| running_valid/task, miss_mask, time, counts
//   cfg     | sink      | cfg_we             | cfg_index, cfg_wdata
//
// a tick item releases in its accept cycle, then the best candidate walks the cell row
// one cell per cycle, then the item retires in the output state; a load item goes
// straight to the output state; one item is in work at a time
// a finished result waits in the output register; the next item is accepted meanwhile
// and retires once out_stall frees the register
// rst_n is synchronous; it clears time, counters, remaining work and the control registers, not the result fields
`default_nettype none

module periodic_task_tick_scheduler_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_opcode,
  input  wire logic [ptts_pkg::TASK_W-1:0]       in_task_index,
  input  wire logic [ptts_pkg::TIME_W-1:0]       in_task_arrival,
  input  wire logic [ptts_pkg::PER_W-1:0]        in_task_period,
  input  wire logic [ptts_pkg::PER_W-1:0]        in_task_burst,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_running_valid,
  output logic [ptts_pkg::TASK_W-1:0]            out_running_task,
  output logic [ptts_pkg::MASK_W-1:0]            out_miss_mask,
  output logic [ptts_pkg::TIME_W-1:0]            out_tick_time,
  output logic [ptts_pkg::TIME_W-1:0]            out_busy_ticks,
  output logic [ptts_pkg::TIME_W-1:0]            out_miss_total,
  input  wire logic                              cfg_we,
  input  wire logic [ptts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ptts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ptts_pkg::*;

  st_t               state_r;
  st_t               state_nxt;
  logic [IDX_W-1:0]  scan_cnt_r;
  logic [IDX_W-1:0]  scan_cnt_nxt;
  logic              is_tick_r;
  logic              policy_r;
  logic [CNT_W-1:0]  task_count_r;
  logic [TIME_W-1:0] now_time_r;
  logic [TIME_W-1:0] busy_count_r;
  logic [TIME_W-1:0] miss_count_r;
  logic [TIME_W-1:0] now_nxt;
  logic [TIME_W-1:0] busy_nxt;
  logic [TIME_W-1:0] miss_nxt;
  logic [TIME_W:0]   miss_sum;
  logic              out_valid_r;

  logic              in_acc;
  logic              rel_pulse;
  logic              finish;
  logic              ran;
  logic [MASK_W-1:0] mask_nxt;

  cell_ctl_t         ctl    [NUM_TASKS];
  chain_t            cin    [NUM_TASKS];
  chain_t            chain  [NUM_TASKS];
  logic [NUM_TASKS-1:0] missed;
  chain_t            last;

  assign in_acc = in_valid && !in_stall;
  assign last   = chain[NUM_TASKS-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_opcode == OP_TICK) ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == IDX_W'(NUM_TASKS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    rel_pulse    = 1'b0;
    finish       = 1'b0;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        rel_pulse    = in_valid && (in_opcode == OP_TICK);
        scan_cnt_nxt = '0;
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
      end
      ST_OUT: begin
        finish = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
      is_tick_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (in_acc) begin
        is_tick_r <= (in_opcode == OP_TICK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= 1'b0;
      task_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY: policy_r     <= cfg_wdata[0];
        CFG_COUNT:  task_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // row of task cells; the best candidate moves one cell per cycle
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cin[i] = '0;
    end else begin : g_link
      assign cin[i] = chain[i-1];
    end

    assign ctl[i].act = CMP_W'(i) < CMP_W'(task_count_r);
    assign ctl[i].rel = rel_pulse;
    assign ctl[i].ld  = in_acc && (in_opcode == OP_LOAD)
                        && (CMP_W'(in_task_index) == CMP_W'(i));
    assign ctl[i].dec = finish && is_tick_r && last.found && (last.sel == IDX_W'(i));

    ptts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[i]),
      .cell_idx   (IDX_W'(i)),
      .policy     (policy_r),
      .now_time   (now_time_r),
      .ld_arrival (in_task_arrival),
      .ld_period  (in_task_period),
      .ld_burst   (in_task_burst),
      .chain_in   (cin[i]),
      .chain_out  (chain[i]),
      .missed     (missed[i])
    );
  end

  assign ran      = is_tick_r && last.found;
  assign miss_sum = {1'b0, miss_count_r} + (TIME_W + 1)'(last.misses);

  always_comb begin
    mask_nxt = '0;
    for (int i = 0; i < MASK_N; i++) begin
      mask_nxt[i] = missed[i];
    end
    if (!is_tick_r) begin
      mask_nxt = '0;
    end
  end

  always_comb begin
    now_nxt  = now_time_r;
    busy_nxt = busy_count_r;
    miss_nxt = miss_count_r;
    if (is_tick_r) begin
      if (now_time_r != '1) begin
        now_nxt = now_time_r + TIME_W'(1);
      end
      if (last.found && busy_count_r != '1) begin
        busy_nxt = busy_count_r + TIME_W'(1);
      end
      miss_nxt = miss_sum[TIME_W] ? '1 : miss_sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_time_r   <= '0;
      busy_count_r <= '0;
      miss_count_r <= '0;
    end else if (finish) begin
      now_time_r   <= now_nxt;
      busy_count_r <= busy_nxt;
      miss_count_r <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_running_valid <= ran;
      out_running_task  <= ran ? TASK_W'(last.sel) : '0;
      out_miss_mask     <= mask_nxt;
      out_tick_time     <= now_time_r;
      out_busy_ticks    <= busy_nxt;
      out_miss_total    <= miss_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared outside the retire state");

  a_mask_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> $countones(mask_nxt) <= int'(last.misses) || !is_tick_r)
    else $error("miss mask has more bits than counted misses");

  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> now_time_r >= $past(now_time_r))
    else $error("time went backwards");

  a_busy_only_ran: assert property (@(posedge clk) disable iff (!rst_n)
    finish && !ran |=> $stable(busy_count_r))
    else $error("busy count moved on an idle or load item");

  a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && scan_cnt_r != IDX_W'(NUM_TASKS - 1) |=> state_r == ST_SCAN)
    else $error("scan left the row early");

endmodule

`default_nettype wire

// File: rtl/core/ptts_cell.sv
// ptts_cell: one task entry plus its stage of the selection chain
// depends on ptts_pkg
`default_nettype none

module ptts_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ptts_pkg::cell_ctl_t           ctl,
  input  wire logic [ptts_pkg::IDX_W-1:0]    cell_idx,
  input  wire logic                          policy,
  input  wire logic [ptts_pkg::TIME_W-1:0]   now_time,
  input  wire logic [ptts_pkg::TIME_W-1:0]   ld_arrival,
  input  wire logic [ptts_pkg::PER_W-1:0]    ld_period,
  input  wire logic [ptts_pkg::PER_W-1:0]    ld_burst,
  input  wire ptts_pkg::chain_t              chain_in,
  output ptts_pkg::chain_t                   chain_out,
  output logic                               missed
);
  import ptts_pkg::*;

  logic [PER_W-1:0]  work_left_r;
  logic [TIME_W-1:0] release_r;
  logic [TIME_W-1:0] deadline_r;
  logic [PER_W-1:0]  period_r;
  logic [PER_W-1:0]  burst_r;
  logic              missed_r;
  chain_t            chain_r;
  chain_t            chain_nxt;
  logic              hit;
  logic              elig;
  logic [TIME_W-1:0] key;
  logic [TIME_W-1:0] next_rel;

  assign hit      = ctl.act && (release_r == now_time);
  assign next_rel = release_r + TIME_W'(period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_left_r <= '0;
      missed_r    <= 1'b0;
    end else if (ctl.ld) begin
      work_left_r <= '0;
    end else if (ctl.rel) begin
      missed_r <= hit && (work_left_r != '0);
      if (hit) begin
        work_left_r <= burst_r;
      end
    end else if (ctl.dec) begin
      work_left_r <= work_left_r - PER_W'(1);
    end
  end

  // entry payload, no reset: undefined until loaded
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      release_r  <= ld_arrival;
      deadline_r <= ld_arrival + TIME_W'(ld_period);
      period_r   <= ld_period;
      burst_r    <= ld_burst;
    end else if (ctl.rel && hit) begin
      release_r  <= next_rel;
      deadline_r <= next_rel;
    end
  end

  assign elig = ctl.act && (work_left_r != '0);
  assign key  = policy ? deadline_r : TIME_W'(period_r);

  // strict less-than keeps the lower index on ties
  always_comb begin
    chain_nxt        = chain_in;
    chain_nxt.misses = chain_in.misses + MCNT_W'(missed_r);
    if (elig && (!chain_in.found || key < chain_in.key)) begin
      chain_nxt.found = 1'b1;
      chain_nxt.key   = key;
      chain_nxt.sel   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  assign chain_out = chain_r;
  assign missed    = missed_r;

endmodule

`default_nettype wire

// File: dv/tb_periodic_task_tick_scheduler_core.sv
// tb_periodic_task_tick_scheduler_core: self-checking bench for the periodic task tick scheduler
// predicts every result in step with accepted items and checks the result channel field by field
// depends on ptts_pkg and periodic_task_tick_scheduler_core
module tb_periodic_task_tick_scheduler_core;
  import ptts_pkg::*;

  typedef struct {
    logic              opcode;
    logic [TASK_W-1:0] index;
    logic [TIME_W-1:0] arrival;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  burst;
  } sched_item_t;

  typedef struct {
    logic              ran;
    logic [TASK_W-1:0] ran_task;
    logic [MASK_W-1:0] missed;
    logic [TIME_W-1:0] tick_at;
    logic [TIME_W-1:0] busy;
    logic [TIME_W-1:0] miss_sum;
  } sched_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_LOAD;
  logic [TASK_W-1:0]     in_task_index = '0;
  logic [TIME_W-1:0]     in_task_arrival = '0;
  logic [PER_W-1:0]      in_task_period = '0;
  logic [PER_W-1:0]      in_task_burst = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_running_valid;
  logic [TASK_W-1:0]     out_running_task;
  logic [MASK_W-1:0]     out_miss_mask;
  logic [TIME_W-1:0]     out_tick_time;
  logic [TIME_W-1:0]     out_busy_ticks;
  logic [TIME_W-1:0]     out_miss_total;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // scheduler state as the block should hold it
  logic [PER_W-1:0]  p_work     [NUM_TASKS] = '{default: '0};
  logic [TIME_W-1:0] p_release  [NUM_TASKS] = '{default: '0};
  logic [TIME_W-1:0] p_deadline [NUM_TASKS] = '{default: '0};
  logic [PER_W-1:0]  p_period   [NUM_TASKS] = '{default: '0};
  logic [PER_W-1:0]  p_burst    [NUM_TASKS] = '{default: '0};
  logic [TIME_W-1:0] p_now = '0;
  logic [TIME_W-1:0] p_busy = '0;
  logic [TIME_W-1:0] p_misses = '0;
  logic              p_edf = 1'b0;
  logic [CNT_W-1:0]  p_count = '0;

  sched_item_t item_backlog [$];
  sched_out_t  due_results [$];
  sched_item_t on_bus;
  int          send_gap = 0;
  int          stall_left = 0;
  logic        send_jitter = 1'b1;
  logic        recv_jitter = 1'b1;
  int          fails = 0;
  logic [TIME_W-1:0] gen_now = '0;

  periodic_task_tick_scheduler_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_task_index    (in_task_index),
    .in_task_arrival  (in_task_arrival),
    .in_task_period   (in_task_period),
    .in_task_burst    (in_task_burst),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_running_valid(out_running_valid),
    .out_running_task (out_running_task),
    .out_miss_mask    (out_miss_mask),
    .out_tick_time    (out_tick_time),
    .out_busy_ticks   (out_busy_ticks),
    .out_miss_total   (out_miss_total),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // applies one item to the predicted state and returns the result it causes
  function automatic sched_out_t schedule_item(input sched_item_t it);
    sched_out_t        r;
    int                n_act;
    logic              found;
    logic [TIME_W-1:0] best_key;
    logic [TIME_W-1:0] key;
    logic [TASK_W-1:0] pick;
    r = '{default: '0};
    r.tick_at = p_now;
    if (it.opcode == OP_LOAD) begin
      p_release[it.index]  = it.arrival;
      p_work[it.index]     = '0;
      p_deadline[it.index] = it.arrival + TIME_W'(it.period);
      p_period[it.index]   = it.period;
      p_burst[it.index]    = it.burst;
      r.busy = p_busy;
      r.miss_sum = p_misses;
      return r;
    end
    n_act = (p_count > NUM_TASKS) ? NUM_TASKS : int'(p_count);
    for (int i = 0; i < n_act; i++) begin
      if (p_release[i] == p_now) begin
        if (p_work[i] != 0) begin
          r.missed[i] = 1'b1;
          if (p_misses != '1) p_misses = p_misses + 1;
        end
        p_work[i] = p_burst[i];
        p_release[i] = p_release[i] + TIME_W'(p_period[i]);
        p_deadline[i] = p_release[i];
      end
    end
    found = 1'b0;
    best_key = '0;
    pick = '0;
    for (int i = 0; i < n_act; i++) begin
      if (p_work[i] != 0) begin
        key = p_edf ? p_deadline[i] : TIME_W'(p_period[i]);
        if (!found || key < best_key) begin
          found = 1'b1;
          best_key = key;
          pick = TASK_W'(i);
        end
      end
    end
    if (found) begin
      p_work[pick] = p_work[pick] - PER_W'(1);
      if (p_busy != '1) p_busy = p_busy + 1;
    end
    if (p_now != '1) p_now = p_now + 1;
    r.ran = found;
    r.ran_task = found ? pick : '0;
    r.busy = p_busy;
    r.miss_sum = p_misses;
    return r;
  endfunction

  function automatic int field_differs(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, fname, want, got);
      return 1;
    end
    return 0;
  endfunction

  // driver: presents queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(schedule_item(on_bus));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (item_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else if (send_jitter && $urandom_range(0, 4) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 6);
        end else begin
          on_bus = item_backlog.pop_front();
          in_valid        <= 1'b1;
          in_opcode       <= on_bus.opcode;
          in_task_index   <= on_bus.index;
          in_task_arrival <= on_bus.arrival;
          in_task_period  <= on_bus.period;
          in_task_burst   <= on_bus.burst;
        end
      end
    end
  end

  // monitor: random stall bursts, checks each accepted result
  always @(posedge clk) begin
    sched_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: running_task %0d tick_time %0h", $time,
                   out_running_task, out_tick_time);
          fails = fails + 1;
        end else begin
          want = due_results.pop_front();
          fails = fails + field_differs("running_valid", 32'(want.ran),
                                        32'(out_running_valid));
          fails = fails + field_differs("running_task", 32'(want.ran_task),
                                        32'(out_running_task));
          fails = fails + field_differs("miss_mask", 32'(want.missed), 32'(out_miss_mask));
          fails = fails + field_differs("tick_time", want.tick_at, out_tick_time);
          fails = fails + field_differs("busy_ticks", want.busy, out_busy_ticks);
          fails = fails + field_differs("miss_total", want.miss_sum, out_miss_total);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (recv_jitter && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_load(input logic [TASK_W-1:0] idx, input logic [TIME_W-1:0] arr,
                            input logic [PER_W-1:0] per, input logic [PER_W-1:0] bur);
    sched_item_t it;
    it.opcode = OP_LOAD;
    it.index = idx;
    it.arrival = arr;
    it.period = per;
    it.burst = bur;
    item_backlog.push_back(it);
  endtask

  // tick items carry random junk in the unused fields
  task automatic queue_tick();
    sched_item_t it;
    it.opcode = OP_TICK;
    it.index = TASK_W'($urandom);
    it.arrival = $urandom;
    it.period = PER_W'($urandom);
    it.burst = PER_W'($urandom);
    item_backlog.push_back(it);
    gen_now = gen_now + 1;
  endtask

  task automatic queue_random(input int n);
    logic [TASK_W-1:0] idx;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 20) begin
        idx = TASK_W'($urandom_range(0, NUM_TASKS - 1));
        // mostly releases just ahead of the current time so tasks keep competing
        if ($urandom_range(0, 9) == 0)
          queue_load(idx, $urandom, PER_W'($urandom), PER_W'($urandom));
        else
          queue_load(idx, gen_now + $urandom_range(0, 20), PER_W'($urandom_range(0, 24)),
                     PER_W'($urandom_range(0, 8)));
      end else begin
        queue_tick();
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_POLICY) p_edf = val[0];
    else if (idx == CFG_COUNT) p_count = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle_block();
    while (item_backlog.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic run_phase(input logic edf, input logic [CNT_W-1:0] count, input int n,
                           input logic jitter);
    settle_block();
    write_reg(CFG_POLICY, CFG_DATA_W'(edf));
    write_reg(CFG_COUNT, count);
    send_jitter = jitter;
    recv_jitter = jitter;
    queue_random(n);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no active tasks: idle tick, then fill every entry
    queue_tick();
    queue_load(0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    queue_load(1, gen_now, 16'h0000, 16'h0000);
    queue_load(2, gen_now + 1, 4, 2);
    queue_load(3, gen_now + 1, 4, 1);
    queue_load(4, gen_now, 3, 2);
    queue_load(5, gen_now + 2, 1, 1);
    queue_load(6, gen_now + 3, 6, 0);
    queue_load(7, gen_now + 2, 16'h8000, 16'h7FFF);
    settle_block();
    write_reg(CFG_POLICY, CFG_DATA_W'(0));
    write_reg(CFG_COUNT, CFG_DATA_W'(8));
    repeat (6) queue_tick();
    // zero period task, and an overloaded task that misses on every tick after its first release
    queue_load(1, gen_now + 1, 16'h0000, 3);
    queue_load(2, gen_now, 1, 16'hFFFF);
    settle_block();
    write_reg(CFG_POLICY, CFG_DATA_W'(1));
    write_reg(CFG_COUNT, CFG_DATA_W'(15));
    repeat (6) queue_tick();

    run_phase(1'b0, 8, 300, 1'b1);
    run_phase(1'b1, 8, 300, 1'b1);
    run_phase(1'b0, 3, 200, 1'b0);
    run_phase(1'b1, 1, 200, 1'b1);
    run_phase(1'b0, 0, 100, 1'b1);
    run_phase(1'b1, 12, 250, 1'b1);
    run_phase(1'b0, 5, 250, 1'b1);
    run_phase(1'b1, 8, 350, 1'b0);
    settle_block();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
rtl/core/ptts_pkg.sv
rtl/core/ptts_cell.sv
rtl/core/periodic_task_tick_scheduler_core.sv
dv/tb_periodic_task_tick_scheduler_core.sv
